// File: hdl/u8v_pkg.sv
// shared constants for the utf-8 validator with line and column tracking
package u8v_pkg;

	// width of the start line register
	localparam int CFG_LINE_W = 24;

	// default counter widths
	localparam int LINE_BITS_DEF   = 24;
	localparam int COLUMN_BITS_DEF = 16;

	// reset value of the start line register
	localparam logic [CFG_LINE_W-1:0] START_LINE_RST = CFG_LINE_W'(1);

	// byte codes
	localparam logic [7:0] BYTE_NUL     = 8'h00;
	localparam logic [7:0] BYTE_NEWLINE = 8'h0A;
	localparam logic [7:0] BYTE_ASCII_END = 8'h80;
	localparam logic [7:0] BYTE_CONT_END  = 8'hC0;
	localparam logic [7:0] BYTE_LEAD2_MIN = 8'hC2;
	localparam logic [7:0] BYTE_LEAD3_MIN = 8'hE0;
	localparam logic [7:0] BYTE_LEAD4_MIN = 8'hF0;
	localparam logic [7:0] BYTE_LEAD_END  = 8'hF5;
	localparam logic [7:0] BYTE_LEAD_ED   = 8'hED;
	localparam logic [7:0] BYTE_LEAD_F4   = 8'hF4;
	localparam logic [7:0] BYTE_SEC_A0    = 8'hA0;
	localparam logic [7:0] BYTE_SEC_90    = 8'h90;

	// continuation bytes still due after a lead byte
	localparam logic [1:0] PEND_NONE  = 2'd0;
	localparam logic [1:0] PEND_ONE   = 2'd1;
	localparam logic [1:0] PEND_TWO   = 2'd2;
	localparam logic [1:0] PEND_THREE = 2'd3;

endpackage

// File: hdl/u8v_core.sv
// per-byte decode state, line and column counters and first error record
module u8v_core #(
	parameter int LINE_BITS   = u8v_pkg::LINE_BITS_DEF,
	parameter int COLUMN_BITS = u8v_pkg::COLUMN_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [u8v_pkg::CFG_LINE_W-1:0]  start_line,
	input  logic                            step,
	input  logic [7:0]                      text_byte,
	input  logic                            is_last,
	output logic                            res_text_valid,
	output logic [7:0]                      res_bad_byte,
	output logic [LINE_BITS-1:0]            res_line,
	output logic [COLUMN_BITS-1:0]          res_column
);
	import u8v_pkg::*;

	localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
	localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;

	logic [1:0]             pend_q, n_pend;
	logic [7:0]             lead_q, n_lead;
	logic                   second_q, n_second;
	logic [LINE_BITS-1:0]   line_q, n_line;
	logic [COLUMN_BITS-1:0] col_q, n_col;
	logic                   err_q, n_err;
	logic                   stop_q, n_stop;
	logic                   open_q;
	logic [7:0]             rec_byte_q, n_rec_byte;
	logic [LINE_BITS-1:0]   rec_line_q, n_rec_line;
	logic [COLUMN_BITS-1:0] rec_col_q, n_rec_col;

	logic [LINE_BITS-1:0]   line_init;
	logic [LINE_BITS-1:0]   line_cur;
	logic [COLUMN_BITS-1:0] col_plus;
	logic                   flag;
	logic [7:0]             flag_byte;
	logic                   bad;
	logic                   trunc;

	// start line clamped to the line counter range
	generate
		if (LINE_BITS >= CFG_LINE_W) begin : g_wide
			assign line_init = LINE_BITS'(start_line);
		end else begin : g_narrow
			assign line_init = (|start_line[CFG_LINE_W-1:LINE_BITS]) ? LINE_MAX
				: start_line[LINE_BITS-1:0];
		end
	endgenerate

	always_comb begin
		line_cur   = open_q ? line_q : line_init;
		// saturating next column, also the 1-based error column
		col_plus   = (col_q == COL_MAX) ? COL_MAX : col_q + 1'b1;
		n_pend     = pend_q;
		n_lead     = lead_q;
		n_second   = second_q;
		n_line     = line_cur;
		n_col      = col_q;
		n_err      = err_q;
		n_stop     = stop_q;
		n_rec_byte = rec_byte_q;
		n_rec_line = rec_line_q;
		n_rec_col  = rec_col_q;
		flag       = 1'b0;
		flag_byte  = BYTE_NUL;
		bad        = 1'b0;

		if (!err_q && !stop_q) begin
			if (pend_q == PEND_NONE) begin
				if (text_byte == BYTE_NUL) begin
					n_stop = 1'b1;
				end else if (text_byte < BYTE_ASCII_END) begin
					n_col = col_plus;
					if (text_byte == BYTE_NEWLINE) begin
						n_line = (line_cur == LINE_MAX) ? LINE_MAX : line_cur + 1'b1;
						n_col  = '0;
					end
				end else if (text_byte < BYTE_LEAD2_MIN) begin
					flag      = 1'b1;
					flag_byte = text_byte;
				end else if (text_byte < BYTE_LEAD_END) begin
					n_pend   = (text_byte < BYTE_LEAD3_MIN) ? PEND_ONE
						: (text_byte < BYTE_LEAD4_MIN) ? PEND_TWO : PEND_THREE;
					n_lead   = text_byte;
					n_second = 1'b1;
				end else begin
					flag      = 1'b1;
					flag_byte = text_byte;
				end
			end else begin
				bad = (text_byte < BYTE_ASCII_END) || (text_byte >= BYTE_CONT_END);
				if (second_q) begin
					// overlong, surrogate and above-range second bytes
					if (lead_q == BYTE_LEAD3_MIN && text_byte < BYTE_SEC_A0) bad = 1'b1;
					if (lead_q == BYTE_LEAD_ED && text_byte >= BYTE_SEC_A0) bad = 1'b1;
					if (lead_q == BYTE_LEAD4_MIN && text_byte < BYTE_SEC_90) bad = 1'b1;
					if (lead_q == BYTE_LEAD_F4 && text_byte >= BYTE_SEC_90) bad = 1'b1;
				end
				if (bad) begin
					flag      = 1'b1;
					flag_byte = lead_q;
				end else begin
					n_second = 1'b0;
					n_pend   = pend_q - 1'b1;
					if (pend_q == PEND_ONE)
						n_col = col_plus;
				end
			end
		end

		if (flag) begin
			n_err      = 1'b1;
			n_rec_byte = flag_byte;
			n_rec_line = line_cur;
			n_rec_col  = col_plus;
			n_pend     = PEND_NONE;
			n_second   = 1'b0;
		end

		// sequence still open at the last byte: column and line are unchanged
		trunc = is_last && !n_err && !n_stop && (n_pend != PEND_NONE);
		if (trunc) begin
			n_rec_byte = n_lead;
			n_rec_line = line_cur;
			n_rec_col  = col_plus;
		end

		res_text_valid = !(n_err || trunc);
		res_bad_byte   = res_text_valid ? BYTE_NUL : n_rec_byte;
		res_line       = res_text_valid ? '0 : n_rec_line;
		res_column     = res_text_valid ? '0 : n_rec_col;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q     <= PEND_NONE;
			lead_q     <= BYTE_NUL;
			second_q   <= 1'b0;
			line_q     <= '0;
			col_q      <= '0;
			err_q      <= 1'b0;
			stop_q     <= 1'b0;
			open_q     <= 1'b0;
			rec_byte_q <= BYTE_NUL;
			rec_line_q <= '0;
			rec_col_q  <= '0;
		end else if (step) begin
			if (is_last) begin
				pend_q     <= PEND_NONE;
				lead_q     <= BYTE_NUL;
				second_q   <= 1'b0;
				line_q     <= '0;
				col_q      <= '0;
				err_q      <= 1'b0;
				stop_q     <= 1'b0;
				open_q     <= 1'b0;
				rec_byte_q <= BYTE_NUL;
				rec_line_q <= '0;
				rec_col_q  <= '0;
			end else begin
				pend_q     <= n_pend;
				lead_q     <= n_lead;
				second_q   <= n_second;
				line_q     <= n_line;
				col_q      <= n_col;
				err_q      <= n_err;
				stop_q     <= n_stop;
				open_q     <= 1'b1;
				rec_byte_q <= n_rec_byte;
				rec_line_q <= n_rec_line;
				rec_col_q  <= n_rec_col;
			end
		end
	end

endmodule

// File: hdl/utf8_validator_line_column.sv
// top level: input register, start line register, core and verdict register
// order: a byte is registered in the input register and decoded as it
//   advances; the verdict register captures the result of the last byte
// throughput: one byte per cycle; a last byte waits only while an earlier
//   verdict is held in the output register under stall
// reset: all control state clears, start line returns to 1
module utf8_validator_line_column #(
	parameter int LINE_BITS   = u8v_pkg::LINE_BITS_DEF,
	parameter int COLUMN_BITS = u8v_pkg::COLUMN_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start_line_we,
	input  logic [u8v_pkg::CFG_LINE_W-1:0] start_line,
	input  logic                           byte_valid,
	output logic                           byte_stall,
	input  logic [7:0]                     text_byte,
	input  logic                           is_last,
	output logic                           verdict_valid,
	input  logic                           verdict_stall,
	output logic                           text_valid,
	output logic [7:0]                     bad_byte,
	output logic [LINE_BITS-1:0]           error_line,
	output logic [COLUMN_BITS-1:0]         error_column
);
	import u8v_pkg::*;

	logic [CFG_LINE_W-1:0]  start_line_q;
	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   last_s1;
	logic                   advance;
	logic                   res_text_valid;
	logic [7:0]             res_bad_byte;
	logic [LINE_BITS-1:0]   res_line;
	logic [COLUMN_BITS-1:0] res_column;
	logic                   verdict_valid_q;
	logic                   text_valid_q;
	logic [7:0]             bad_byte_q;
	logic [LINE_BITS-1:0]   error_line_q;
	logic [COLUMN_BITS-1:0] error_column_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			start_line_q <= START_LINE_RST;
		else if (start_line_we)
			start_line_q <= start_line;
	end

	// a last byte moves on only when the verdict register is free
	assign advance    = valid_s1 && (!last_s1 || !verdict_valid_q || !verdict_stall);
	assign byte_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!byte_stall)
			valid_s1 <= byte_valid;
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			byte_s1 <= text_byte;
			last_s1 <= is_last;
		end
	end

	u8v_core #(
		.LINE_BITS   (LINE_BITS),
		.COLUMN_BITS (COLUMN_BITS)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.start_line     (start_line_q),
		.step           (advance),
		.text_byte      (byte_s1),
		.is_last        (last_s1),
		.res_text_valid (res_text_valid),
		.res_bad_byte   (res_bad_byte),
		.res_line       (res_line),
		.res_column     (res_column)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			verdict_valid_q <= 1'b0;
		else if (advance && last_s1)
			verdict_valid_q <= 1'b1;
		else if (!verdict_stall)
			verdict_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			text_valid_q   <= res_text_valid;
			bad_byte_q     <= res_bad_byte;
			error_line_q   <= res_line;
			error_column_q <= res_column;
		end
	end

	assign verdict_valid = verdict_valid_q;
	assign text_valid    = text_valid_q;
	assign bad_byte      = bad_byte_q;
	assign error_line    = error_line_q;
	assign error_column  = error_column_q;

	// only a waiting last byte can hold up the input
	a_stall_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> (valid_s1 && last_s1 && verdict_valid_q))
		else $error("input stalled without a pending last byte");

	// a taken verdict leaves unless a new one is loaded
	a_verdict_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(verdict_valid_q && !verdict_stall && !(advance && last_s1)) |=> !verdict_valid_q)
		else $error("verdict repeated after it was taken");

	// a valid verdict carries no error details
	a_valid_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(verdict_valid_q && text_valid_q) |->
			(bad_byte_q == 8'd0 && error_line_q == '0 && error_column_q == '0))
		else $error("valid verdict with error fields set");

	// an error verdict always names a 1-based column and a non-ascii or lead byte
	a_error_column: assert property (@(posedge clk) disable iff (!arst_n)
		(verdict_valid_q && !text_valid_q) |->
			(error_column_q != '0 && bad_byte_q >= BYTE_ASCII_END))
		else $error("error verdict with bad column or byte");

endmodule
